@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the checker file.
// Both macros expect a signal named clock in the enclosing scope; ASSERT_SYNC also expects reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside of reset.
`define ASSERT_SYNC(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ hdl/i2cbed_pkg.sv @@
`default_nettype none

package i2cbed_pkg;

   // Width of timestamps, both on the ports and inside the block.
   localparam int TIME_WIDTH = 32;

   // Bits in one bus byte.
   localparam int BYTE_BITS = 8;
   localparam int COUNT_WIDTH = $clog2(BYTE_BITS + 1);
   localparam int ADDR_WIDTH = BYTE_BITS - 1;

   // Protocol phase of the monitor; the three unused codes behave as idle.
   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_ADDR     = 3'd1,
      PH_ADDR_ACK = 3'd2,
      PH_DATA     = 3'd3,
      PH_DATA_ACK = 3'd4
   } phase_type;

   // Kind of a reported bus event.
   typedef enum logic [2:0] {
      EV_START = 3'd0,
      EV_STOP  = 3'd1,
      EV_ADDR  = 3'd2,
      EV_DATA  = 3'd3,
      EV_ACK   = 3'd4,
      EV_NAK   = 3'd5
   } event_kind_type;

   // One sample of the bus lines.
   typedef struct packed {
      logic                  first_sample;
      logic                  scl_level;
      logic                  sda_level;
      logic [TIME_WIDTH-1:0] sample_time;
   } sample_type;

   // One decoded bus event.
   typedef struct packed {
      event_kind_type        event_kind;
      logic [BYTE_BITS-1:0]  byte_value;
      logic [ADDR_WIDTH-1:0] target_address;
      logic                  read_flag;
      logic [TIME_WIDTH-1:0] event_start;
      logic [TIME_WIDTH-1:0] event_end;
      logic                  nak_error;
   } event_type;

   // Decoder outcome for the sample in the input register.
   typedef struct packed {
      logic      has_event;
      event_type evt;
   } decode_type;

endpackage

`default_nettype wire

@@ hdl/i2c_bus_event_decoder.sv @@
// Passive I2C bus monitor: each input word is one timestamped sample of SCL and SDA, and
// the block reports START, STOP, address, data byte, ACK and NAK events, at most one per
// sample. A sample flagged as the first of a capture returns the decoder to an idle bus
// with both lines high and gives no event. One sample is taken every clock cycle as long
// as the result side keeps up; each sample is held in the input register, and the event
// it yields is decoded from there into the output register that drives the result port.
// When a result sits unread, samples that produce no event still pass; the first sample
// that produces one waits in the input register until the output register is free.
`default_nettype none

module i2c_bus_event_decoder (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,  // scl_level, sda_level, sample_time[31:0], zero fill
   input  wire  [0:0]  req_tuser,  // first_sample
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [79:0] rsp_tdata,  // byte_value, target_address, read_flag,
                                   // event_start[31:0], event_end[31:0]
   output logic [3:0]  rsp_tuser   // event_kind[2:0], nak_error
);

   logic                   sample_valid;
   i2cbed_pkg::sample_type sample;
   i2cbed_pkg::decode_type decode;
   i2cbed_pkg::event_type  evt_out;
   logic                   out_valid;
   logic                   advance;

   // The sample retires unless it has an event and the output slot stays full.
   assign advance    = sample_valid && (!decode.has_event || !out_valid || rsp_tready);
   assign req_tready = !sample_valid || advance;

   i2cbed_in_stage u_in_stage (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .first_sample (req_tuser[0]),
      .scl_level    (req_tdata[0]),
      .sda_level    (req_tdata[1]),
      .sample_time  (req_tdata[i2cbed_pkg::TIME_WIDTH+1:2]),
      .advance      (advance),
      .sample_valid (sample_valid),
      .sample       (sample)
   );

   i2cbed_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .sample  (sample),
      .advance (advance),
      .decode  (decode)
   );

   i2cbed_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && decode.has_event),
      .evt_in     (decode.evt),
      .rsp_tready (rsp_tready),
      .rsp_valid  (out_valid),
      .evt_out    (evt_out)
   );

   // Pack the result word.
   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {evt_out.event_end, evt_out.event_start, evt_out.read_flag,
                        evt_out.target_address, evt_out.byte_value};
   assign rsp_tuser  = {evt_out.nak_error, evt_out.event_kind};

endmodule

`default_nettype wire

@@ hdl/i2cbed_in_stage.sv @@
`default_nettype none

module i2cbed_in_stage (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   input  wire                     req_tready,
   input  wire                     first_sample,
   input  wire                     scl_level,
   input  wire                     sda_level,
   input  wire [i2cbed_pkg::TIME_WIDTH-1:0] sample_time,
   input  wire                     advance,
   output logic                    sample_valid,
   output i2cbed_pkg::sample_type  sample
);

   logic                   valid_ff;
   logic                   valid_in;
   i2cbed_pkg::sample_type sample_ff;
   logic                   load;

   // A word is taken whenever the slot is empty or drains this cycle.
   assign load = req_tvalid && req_tready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register, no reset needed.
   always_ff @(posedge clock) begin
      if (load) begin
         sample_ff.first_sample <= first_sample;
         sample_ff.scl_level    <= scl_level;
         sample_ff.sda_level    <= sda_level;
         sample_ff.sample_time  <= sample_time;
      end
   end

   assign sample_valid = valid_ff;
   assign sample       = sample_ff;

endmodule

`default_nettype wire

@@ hdl/i2cbed_decode.sv @@
`default_nettype none

module i2cbed_decode (
   input  wire                     clock,
   input  wire                     reset,
   input  i2cbed_pkg::sample_type  sample,
   input  wire                     advance,
   output i2cbed_pkg::decode_type  decode
);

   i2cbed_pkg::phase_type                  phase_ff, phase_in;
   logic [i2cbed_pkg::COUNT_WIDTH-1:0]     count_ff, count_in;
   logic [i2cbed_pkg::BYTE_BITS-1:0]       shift_ff, shift_in;
   logic                                   last_scl_ff, last_scl_in;
   logic                                   last_sda_ff, last_sda_in;
   logic [i2cbed_pkg::TIME_WIDTH-1:0]      seg_start_ff, seg_start_in;

   logic                                   scl_high_both;
   logic                                   clk_rise;
   logic [i2cbed_pkg::BYTE_BITS-1:0]       shifted;
   logic [i2cbed_pkg::COUNT_WIDTH-1:0]     count_inc;
   logic                                   in_byte;
   logic                                   in_ack;
   logic [i2cbed_pkg::TIME_WIDTH-1:0]      t;

   // State registers only move when the sample in the input register retires.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= i2cbed_pkg::PH_IDLE;
         count_ff     <= '0;
         shift_ff     <= '0;
         last_scl_ff  <= 1'b1;
         last_sda_ff  <= 1'b1;
         seg_start_ff <= '0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         shift_ff     <= shift_in;
         last_scl_ff  <= last_scl_in;
         last_sda_ff  <= last_sda_in;
         seg_start_ff <= seg_start_in;
      end
   end

   // Line edge detection against the previous sample.
   assign t             = sample.sample_time;
   assign scl_high_both = last_scl_ff && sample.scl_level;
   assign clk_rise      = !last_scl_ff && sample.scl_level;
   assign shifted       = {shift_ff[i2cbed_pkg::BYTE_BITS-2:0], sample.sda_level};
   assign count_inc     = count_ff + 1'b1;

   // Phase decode; unused codes fall into the idle group.
   always_comb begin
      case (phase_ff)
         i2cbed_pkg::PH_ADDR, i2cbed_pkg::PH_DATA: begin
            in_byte = 1'b1;
            in_ack  = 1'b0;
         end
         i2cbed_pkg::PH_ADDR_ACK, i2cbed_pkg::PH_DATA_ACK: begin
            in_byte = 1'b0;
            in_ack  = 1'b1;
         end
         default: begin
            in_byte = 1'b0;
            in_ack  = 1'b0;
         end
      endcase
   end

   // Next state and the event for this sample.
   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      shift_in     = shift_ff;
      seg_start_in = seg_start_ff;
      last_scl_in  = sample.scl_level;
      last_sda_in  = sample.sda_level;

      decode.has_event          = 1'b0;
      decode.evt.event_kind     = i2cbed_pkg::EV_START;
      decode.evt.byte_value     = '0;
      decode.evt.target_address = '0;
      decode.evt.read_flag      = 1'b0;
      decode.evt.event_start    = t;
      decode.evt.event_end      = t;
      decode.evt.nak_error      = 1'b0;

      if (sample.first_sample) begin
         // Capture start: back to the idle bus, sample discarded.
         phase_in     = i2cbed_pkg::PH_IDLE;
         count_in     = '0;
         shift_in     = '0;
         seg_start_in = '0;
         last_scl_in  = 1'b1;
         last_sda_in  = 1'b1;
      end else if (scl_high_both && last_sda_ff && !sample.sda_level) begin
         // Start or repeated start.
         decode.has_event      = 1'b1;
         decode.evt.event_kind = i2cbed_pkg::EV_START;
         phase_in              = i2cbed_pkg::PH_ADDR;
         count_in              = '0;
         shift_in              = '0;
         seg_start_in          = t;
      end else if (scl_high_both && !last_sda_ff && sample.sda_level) begin
         // Stop returns to idle and keeps the rest.
         decode.has_event      = 1'b1;
         decode.evt.event_kind = i2cbed_pkg::EV_STOP;
         phase_in              = i2cbed_pkg::PH_IDLE;
      end else if (clk_rise && in_byte) begin
         shift_in = shifted;
         count_in = count_inc;
         if (count_inc == i2cbed_pkg::COUNT_WIDTH'(i2cbed_pkg::BYTE_BITS)) begin
            // Byte complete: address after a start, data otherwise.
            decode.has_event       = 1'b1;
            decode.evt.byte_value  = shifted;
            decode.evt.event_start = seg_start_ff;
            if (phase_ff == i2cbed_pkg::PH_ADDR) begin
               decode.evt.event_kind     = i2cbed_pkg::EV_ADDR;
               decode.evt.target_address = shifted[i2cbed_pkg::BYTE_BITS-1:1];
               decode.evt.read_flag      = shifted[0];
               phase_in                  = i2cbed_pkg::PH_ADDR_ACK;
            end else begin
               decode.evt.event_kind = i2cbed_pkg::EV_DATA;
               phase_in              = i2cbed_pkg::PH_DATA_ACK;
            end
            count_in     = '0;
            shift_in     = '0;
            seg_start_in = t;
         end
      end else if (clk_rise && in_ack) begin
         // Acknowledge bit: a high data line is a NAK.
         decode.has_event       = 1'b1;
         decode.evt.event_kind  = sample.sda_level ? i2cbed_pkg::EV_NAK : i2cbed_pkg::EV_ACK;
         decode.evt.event_start = seg_start_ff;
         decode.evt.nak_error   = sample.sda_level;
         phase_in               = i2cbed_pkg::PH_DATA;
         count_in               = '0;
         shift_in               = '0;
         seg_start_in           = t;
      end
   end

endmodule

`default_nettype wire

@@ hdl/i2cbed_out_reg.sv @@
`default_nettype none

module i2cbed_out_reg (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    load,
   input  i2cbed_pkg::event_type  evt_in,
   input  wire                    rsp_tready,
   output logic                   rsp_valid,
   output i2cbed_pkg::event_type  evt_out
);

   logic                  valid_ff;
   logic                  valid_in;
   i2cbed_pkg::event_type evt_ff;

   // Hold a word until the consumer takes it; a new one may replace it then.
   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         evt_ff <= evt_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign evt_out   = evt_ff;

endmodule

`default_nettype wire

@@ hdl/i2cbed_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module i2cbed_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [79:0] rsp_tdata,
   input wire [3:0]  rsp_tuser
);

   logic is_nak;
   logic is_addr;
   logic is_edge;
   logic addr_ok;

   assign is_nak  = rsp_tuser[2:0] == i2cbed_pkg::EV_NAK;
   assign is_addr = rsp_tuser[2:0] == i2cbed_pkg::EV_ADDR;
   assign is_edge = rsp_tuser[2:0] == i2cbed_pkg::EV_START ||
                    rsp_tuser[2:0] == i2cbed_pkg::EV_STOP;

   // For an address the address and read flag rebuild the byte; otherwise both are zero.
   assign addr_ok = is_addr ? ({rsp_tdata[14:8], rsp_tdata[15]} == rsp_tdata[7:0])
                            : (rsp_tdata[15:8] == 8'd0);

   // No word comes out in the cycle after reset.
   `ASSERT_ALWAYS(a_idle_after_reset, reset |=> !rsp_tvalid, "result valid after reset")

   // A waiting word stays and keeps its payload.
   `ASSERT_SYNC(a_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled word changed")

   // The error flag goes with NAK events only.
   `ASSERT_SYNC(a_nak_flag, rsp_tvalid |-> rsp_tuser[3] == is_nak, "NAK flag mismatch")

   // Address fields are the received byte split, and zero for other events.
   `ASSERT_SYNC(a_addr_split, rsp_tvalid |-> addr_ok, "address fields mismatch")

   // START and STOP are instants.
   `ASSERT_SYNC(a_edge_time, rsp_tvalid && is_edge |-> rsp_tdata[47:16] == rsp_tdata[79:48], "start or stop spans time")

endmodule

bind i2c_bus_event_decoder i2cbed_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

@@ bench/i2c_bus_event_decoder_tb.sv @@
module i2c_bus_event_decoder_tb;
   import i2cbed_pkg::*;

   localparam int DIRECTED_ROWS = 28;
   localparam int ITEM_TOTAL = DIRECTED_ROWS + 1350;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PRINT_LIMIT = 200;

   // One row of the directed table; a typed row carries a START or STOP at its own time.
   typedef struct {
      logic           first;
      logic           scl;
      logic           sda;
      logic [31:0]    t;
      bit             typed_ok;
      event_kind_type kind;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;  // scl_level, sda_level, sample_time[31:0], zero fill
   logic [0:0]  req_tuser = '0;  // first_sample
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;       // byte_value, target_address, read_flag,
                                 // event_start[31:0], event_end[31:0]
   logic [3:0]  rsp_tuser;       // event_kind[2:0], nak_error

   // Bus tracker state mirrored from the decoder.
   phase_type   bus_phase;
   logic [3:0]  shadow_count;
   logic [7:0]  shadow_byte;
   logic        bus_scl;
   logic        bus_sda;
   logic [31:0] segment_start;

   event_type    pending_events[$];
   stim_row_type directed_rows[0:DIRECTED_ROWS-1];
   int           err_count = 0;
   int           sent_count = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   int           cycle_count = 0;
   logic [31:0]  bus_time = '0;

   i2c_bus_event_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Free-running clock.
   initial begin
      forever #6 clock = ~clock;
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // The receiver stalls at random according to the current pressure phase.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                  input logic [31:0] want_v);
      if (err_count < PRINT_LIMIT)
         $display("mismatch on %s: got %0h, expected %0h", what, got_v, want_v);
      err_count++;
   endtask

   function automatic void clear_bus_state();
      bus_phase = PH_IDLE;
      shadow_count = '0;
      shadow_byte = '0;
      bus_scl = 1'b1;
      bus_sda = 1'b1;
      segment_start = '0;
   endfunction

   // Advances the bus tracker by one sample and tells whether it yields an event.
   function automatic bit decode_sample(input logic first, input logic scl, input logic sda,
                                        input logic [31:0] t, output event_type ev);
      bit         hit;
      logic [7:0] next_byte;
      logic [3:0] next_count;
      ev = '0;
      hit = 1'b0;
      if (first) begin
         clear_bus_state();
         return 1'b0;
      end
      if (bus_scl && scl && bus_sda && !sda) begin
         // Data falls with the clock high: start, repeated or not.
         ev.event_kind = EV_START;
         ev.event_start = t;
         ev.event_end = t;
         bus_phase = PH_ADDR;
         shadow_count = '0;
         shadow_byte = '0;
         segment_start = t;
         hit = 1'b1;
      end else if (bus_scl && scl && !bus_sda && sda) begin
         // Data rises with the clock high: stop.
         ev.event_kind = EV_STOP;
         ev.event_start = t;
         ev.event_end = t;
         bus_phase = PH_IDLE;
         hit = 1'b1;
      end else if (!bus_scl && scl) begin
         if (bus_phase == PH_ADDR || bus_phase == PH_DATA) begin
            next_byte = {shadow_byte[6:0], sda};
            next_count = shadow_count + 4'd1;
            shadow_byte = next_byte;
            shadow_count = next_count;
            if (next_count == 4'd8) begin
               ev.byte_value = next_byte;
               ev.event_start = segment_start;
               ev.event_end = t;
               if (bus_phase == PH_ADDR) begin
                  ev.event_kind = EV_ADDR;
                  ev.target_address = next_byte[7:1];
                  ev.read_flag = next_byte[0];
                  bus_phase = PH_ADDR_ACK;
               end else begin
                  ev.event_kind = EV_DATA;
                  bus_phase = PH_DATA_ACK;
               end
               shadow_count = '0;
               shadow_byte = '0;
               segment_start = t;
               hit = 1'b1;
            end
         end else if (bus_phase == PH_ADDR_ACK || bus_phase == PH_DATA_ACK) begin
            // The ninth bit: low acknowledges, high refuses.
            if (sda)
               ev.event_kind = EV_NAK;
            else
               ev.event_kind = EV_ACK;
            ev.nak_error = sda;
            ev.event_start = segment_start;
            ev.event_end = t;
            bus_phase = PH_DATA;
            shadow_count = '0;
            shadow_byte = '0;
            segment_start = t;
            hit = 1'b1;
         end
      end
      bus_scl = scl;
      bus_sda = sda;
      return hit;
   endfunction

   // Sends one sample word and records the event it should cause once it is taken.
   task automatic apply_sample(input logic first, input logic scl, input logic sda,
                               input logic [31:0] t, input bit typed_ok,
                               input event_type typed_ev);
      event_type ev;
      bit        hit;
      if (sent_count < 460) begin
         send_idle_pct = 36;
         recv_stall_pct = 64;
      end else if (sent_count < 920) begin
         send_idle_pct = 64;
         recv_stall_pct = 36;
      end else begin
         send_idle_pct = 0;
         recv_stall_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, t, sda, scl};
      req_tuser <= first;
      forever begin
         @(negedge clock);
         if (req_tready)
            break;
      end
      @(posedge clock);
      sent_count++;
      hit = decode_sample(first, scl, sda, t, ev);
      if (typed_ok)
         pending_events.insert(pending_events.size(), typed_ev);
      else if (hit)
         pending_events.insert(pending_events.size(), ev);
   endtask

   // Random-phase sample with a timestamp that mostly advances, sometimes jumps.
   task automatic emit(input logic first, input logic scl, input logic sda);
      if ($urandom_range(19) == 0)
         bus_time = $urandom;
      else
         bus_time = bus_time + $urandom_range(1, 1000);
      apply_sample(first, scl, sda, bus_time, 1'b0, event_type'('0));
   endtask

   // One data bit: set data with the clock low, then raise the clock.
   task automatic send_bit(input logic b);
      if ($urandom_range(3) == 0)
         emit(1'b0, 1'b0, ~b);
      emit(1'b0, 1'b0, b);
      emit(1'b0, 1'b1, b);
      if ($urandom_range(4) == 0)
         emit(1'b0, 1'b1, b);
   endtask

   // Compare each result word with the oldest pending event.
   always @(negedge clock) begin
      event_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_events.size() == 0) begin
            report_mismatch("word with no event pending", {28'b0, rsp_tuser}, '0);
         end else begin
            want = pending_events.pop_front();
            if (rsp_tuser[2:0] !== want.event_kind)
               report_mismatch("event_kind", 32'(rsp_tuser[2:0]), 32'(want.event_kind));
            if (rsp_tdata[7:0] !== want.byte_value)
               report_mismatch("byte_value", 32'(rsp_tdata[7:0]), 32'(want.byte_value));
            if (rsp_tdata[14:8] !== want.target_address)
               report_mismatch("target_address", 32'(rsp_tdata[14:8]),
                               32'(want.target_address));
            if (rsp_tdata[15] !== want.read_flag)
               report_mismatch("read_flag", 32'(rsp_tdata[15]), 32'(want.read_flag));
            if (rsp_tdata[47:16] !== want.event_start)
               report_mismatch("event_start", rsp_tdata[47:16], want.event_start);
            if (rsp_tdata[79:48] !== want.event_end)
               report_mismatch("event_end", rsp_tdata[79:48], want.event_end);
            if (rsp_tuser[3] !== want.nak_error)
               report_mismatch("nak_error", 32'(rsp_tuser[3]), 32'(want.nak_error));
         end
      end
   end

   initial begin
      event_type  row_ev;
      logic [7:0] byte_v;
      int         pick;
      int         nbytes;
      int         nbits;

      // Capture start, idle-bus clock edge, stop from idle, start at the top time,
      // address 0xA5 refused, repeated start, capture start mid-frame, then start
      // and stop against lines that were reset high.
      directed_rows = '{
         '{1'b1, 1'b0, 1'b0, 32'h0000_0000, 1'b0, EV_START},
         '{1'b0, 1'b1, 1'b1, 32'h0000_0000, 1'b0, EV_START},
         '{1'b0, 1'b0, 1'b0, 32'h0000_0001, 1'b0, EV_START},
         '{1'b0, 1'b1, 1'b0, 32'h0000_0002, 1'b0, EV_START},
         '{1'b0, 1'b1, 1'b1, 32'h0000_0003, 1'b1, EV_STOP},
         '{1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b1, EV_START},
         '{1'b0, 1'b0, 1'b1, 32'd10, 1'b0, EV_START},
         '{1'b0, 1'b1, 1'b1, 32'd11, 1'b0, EV_START},
         '{1'b0, 1'b0, 1'b0, 32'd12, 1'b0, EV_START},
         '{1'b0, 1'b1, 1'b0, 32'd13, 1'b0, EV_START},
         '{1'b0, 1'b0, 1'b1, 32'd14, 1'b0, EV_START},
         '{1'b0, 1'b1, 1'b1, 32'd15, 1'b0, EV_START},
         '{1'b0, 1'b0, 1'b0, 32'd16, 1'b0, EV_START},
         '{1'b0, 1'b1, 1'b0, 32'd17, 1'b0, EV_START},
         '{1'b0, 1'b0, 1'b0, 32'd18, 1'b0, EV_START},
         '{1'b0, 1'b1, 1'b0, 32'd19, 1'b0, EV_START},
         '{1'b0, 1'b0, 1'b1, 32'd20, 1'b0, EV_START},
         '{1'b0, 1'b1, 1'b1, 32'd21, 1'b0, EV_START},
         '{1'b0, 1'b0, 1'b0, 32'd22, 1'b0, EV_START},
         '{1'b0, 1'b1, 1'b0, 32'd23, 1'b0, EV_START},
         '{1'b0, 1'b0, 1'b1, 32'd24, 1'b0, EV_START},
         '{1'b0, 1'b1, 1'b1, 32'd25, 1'b0, EV_START},
         '{1'b0, 1'b0, 1'b1, 32'd26, 1'b0, EV_START},
         '{1'b0, 1'b1, 1'b1, 32'd27, 1'b0, EV_START},
         '{1'b0, 1'b1, 1'b0, 32'd28, 1'b1, EV_START},
         '{1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0, EV_START},
         '{1'b0, 1'b1, 1'b0, 32'hFFFF_FFFE, 1'b1, EV_START},
         '{1'b0, 1'b1, 1'b1, 32'h8000_0000, 1'b1, EV_STOP}
      };

      // Hold reset, then start the tracker from an idle bus.
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      clear_bus_state();

      // Directed table.
      foreach (directed_rows[i]) begin
         row_ev = '0;
         row_ev.event_kind = directed_rows[i].kind;
         row_ev.event_start = directed_rows[i].t;
         row_ev.event_end = directed_rows[i].t;
         apply_sample(directed_rows[i].first, directed_rows[i].scl, directed_rows[i].sda,
                      directed_rows[i].t, directed_rows[i].typed_ok, row_ev);
      end

      // Random part: mostly well-formed transfers, some noise and broken frames.
      bus_time = $urandom;
      while (sent_count < ITEM_TOTAL) begin
         pick = $urandom_range(99);
         if (pick < 3) begin
            emit(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
         end else if (pick < 10) begin
            repeat ($urandom_range(1, 6))
               emit(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
         end else begin
            // Start condition from both lines high.
            emit(1'b0, 1'b0, 1'b1);
            emit(1'b0, 1'b1, 1'b1);
            emit(1'b0, 1'b1, 1'b0);
            nbytes = $urandom_range(0, 4);
            for (int k = 0; k <= nbytes; k++) begin
               case ($urandom_range(7))
                  0: byte_v = 8'h00;
                  1: byte_v = 8'hFF;
                  default: byte_v = 8'($urandom);
               endcase
               // Now and then the byte is cut short.
               nbits = ($urandom_range(11) == 0) ? $urandom_range(0, 7) : 8;
               for (int b = 7; b >= 8 - nbits; b--)
                  send_bit(byte_v[b]);
               if (nbits < 8)
                  break;
               send_bit($urandom_range(9) == 0);
            end
            // Mostly a stop; otherwise the next start is a repeated one.
            if ($urandom_range(4) != 0) begin
               emit(1'b0, 1'b0, 1'b0);
               emit(1'b0, 1'b1, 1'b0);
               emit(1'b0, 1'b1, 1'b1);
            end
         end
      end
      req_tvalid <= 1'b0;
      recv_stall_pct = 0;

      // Drain, then allow the pipeline to show any stray word.
      while (pending_events.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (err_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
